// ===== rtl/scel_pkg.sv =====
package scel_pkg;

  localparam int MAX_CLASSES = 32;
  localparam int FRAC_BITS   = 16;
  localparam int IDX_W       = $clog2(MAX_CLASSES);
  localparam int LEN_W       = IDX_W + 1;
  localparam int ROW_W       = 24 + 17;
  localparam int DIV_W       = 48;
  localparam int DSR_W       = 22;
  localparam int NB_W        = 6;

  localparam logic [33:0] LN2_Q30 = 34'd744261118;

  localparam logic [2:0] CFG_CLASS_COUNT  = 3'd0;
  localparam logic [2:0] CFG_BATCH_ROWS   = 3'd1;
  localparam logic [2:0] CFG_REDUCTION    = 3'd2;
  localparam logic [2:0] CFG_LOGITS       = 3'd3;
  localparam logic [2:0] CFG_SMOOTHING    = 3'd4;

  localparam logic [1:0] RED_MEAN = 2'd0;

  typedef struct packed {
    logic [5:0]  class_count;
    logic [15:0] batch_rows;
    logic [1:0]  reduction_mode;
    logic        scores_are_logits;
    logic [15:0] smoothing_amount;
  } cfg_t;

  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] len;
  } row_desc_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
    logic [NB_W-1:0]  nbits;
  } div_req_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W:0]   addr;
    logic [ROW_W-1:0] data;
  } row_wr_t;

  // exp(-2^e) in Q30, index e + 24
  function automatic logic [29:0] exp_tab_q30(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd1073741760;
      5'd1:  v = 30'd1073741696;
      5'd2:  v = 30'd1073741568;
      5'd3:  v = 30'd1073741312;
      5'd4:  v = 30'd1073740800;
      5'd5:  v = 30'd1073739776;
      5'd6:  v = 30'd1073737728;
      5'd7:  v = 30'd1073733632;
      5'd8:  v = 30'd1073725440;
      5'd9:  v = 30'd1073709056;
      5'd10: v = 30'd1073676290;
      5'd11: v = 30'd1073610760;
      5'd12: v = 30'd1073479712;
      5'd13: v = 30'd1073217664;
      5'd14: v = 30'd1072693760;
      5'd15: v = 30'd1071646719;
      5'd16: v = 30'd1069555701;
      5'd17: v = 30'd1065385899;
      5'd18: v = 30'd1057095000;
      5'd19: v = 30'd1040706261;
      5'd20: v = 30'd1008687096;
      5'd21: v = 30'd947573834;
      5'd22: v = 30'd836230973;
      5'd23: v = 30'd651257337;
      5'd24: v = 30'd395007542;
      5'd25: v = 30'd145315155;
      5'd26: v = 30'd19666268;
      5'd27: v = 30'd360201;
      5'd28: v = 30'd121;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // ln(1 + 2^-(idx+1)) in Q30
  function automatic logic [28:0] ln_tab_q30(input logic [4:0] idx);
    logic [28:0] v;
    case (idx)
      5'd0:  v = 29'd435364845;
      5'd1:  v = 29'd239598564;
      5'd2:  v = 29'd126468572;
      5'd3:  v = 29'd65095192;
      5'd4:  v = 29'd33040817;
      5'd5:  v = 29'd16647494;
      5'd6:  v = 29'd8356010;
      5'd7:  v = 29'd4186133;
      5'd8:  v = 29'd2095107;
      5'd9:  v = 29'd1048064;
      5'd10: v = 29'd524160;
      5'd11: v = 29'd262112;
      5'd12: v = 29'd131064;
      5'd13: v = 29'd65534;
      5'd14: v = 29'd32768;
      5'd15: v = 29'd16384;
      5'd16: v = 29'd8192;
      5'd17: v = 29'd4096;
      5'd18: v = 29'd2048;
      5'd19: v = 29'd1024;
      5'd20: v = 29'd512;
      5'd21: v = 29'd256;
      5'd22: v = 29'd128;
      5'd23: v = 29'd64;
      5'd24: v = 29'd32;
      5'd25: v = 29'd16;
      5'd26: v = 29'd8;
      5'd27: v = 29'd4;
      5'd28: v = 29'd2;
      5'd29: v = 29'd1;
      default: v = 29'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/scel_in_if.sv =====
interface scel_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] score;
  logic [16:0]        target;

  modport source (output valid, output score, output target, input ready);
  modport sink (input valid, input score, input target, output ready);
endinterface

// ===== rtl/scel_out_if.sv =====
interface scel_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         class_index;
  logic signed [31:0] gradient;
  logic [31:0]        row_loss;
  logic [47:0]        batch_loss;
  logic               last_of_row;
  logic               last_of_batch;

  modport source (output valid, output class_index, output gradient, output row_loss,
                  output batch_loss, output last_of_row, output last_of_batch, input ready);
  modport sink (input valid, input class_index, input gradient, input row_loss,
                input batch_loss, input last_of_row, input last_of_batch, output ready);
endinterface

// ===== rtl/scel_cfg_if.sv =====
interface scel_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/scel_ram.sv =====
module scel_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/scel_queue.sv =====
module scel_queue
  import scel_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  row_desc_t push_desc,
  input  logic      pop,
  output logic      head_valid,
  output row_desc_t head,
  output logic [1:0] count
);

  row_desc_t  ent_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        ent_r[wr_r] <= push_desc;
        wr_r        <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  assign head_valid = (cnt_r != 2'd0);
  assign head       = ent_r[rd_r];
  assign count      = cnt_r;

endmodule

// ===== rtl/scel_front.sv =====
module scel_front
  import scel_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  scel_in_if.sink   in_chan,
  input  cfg_t      cfg,
  input  bank_rel_t rel,
  output row_wr_t   row_wr,
  output logic      push,
  output row_desc_t push_desc
);

  logic             wb_r;
  logic [IDX_W-1:0] idx_r;
  logic [1:0]       busy_r;
  logic [LEN_W-1:0] n_eff;
  logic [LEN_W-1:0] fill;
  logic             accept;
  logic             close;

  always_comb begin
    if (cfg.class_count == '0) begin
      n_eff = LEN_W'(1);
    end else if (cfg.class_count > LEN_W'(MAX_CLASSES)) begin
      n_eff = LEN_W'(MAX_CLASSES);
    end else begin
      n_eff = cfg.class_count;
    end
  end

  assign fill           = LEN_W'(idx_r) + LEN_W'(1);
  assign in_chan.ready  = !busy_r[wb_r];
  assign accept         = in_chan.valid && in_chan.ready;
  // a lowered class count closes the row on the next word
  assign close          = (fill >= n_eff);

  assign row_wr.we      = accept;
  assign row_wr.addr    = {wb_r, idx_r};
  assign row_wr.data    = {in_chan.score, in_chan.target};
  assign push           = accept && close;
  assign push_desc.bank = wb_r;
  assign push_desc.len  = fill;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r   <= 1'b0;
      idx_r  <= '0;
      busy_r <= 2'b00;
    end else begin
      if (rel.valid) begin
        busy_r[rel.bank] <= 1'b0;
      end
      if (accept) begin
        if (close) begin
          busy_r[wb_r] <= 1'b1;
          wb_r         <= ~wb_r;
          idx_r        <= '0;
        end else begin
          idx_r <= idx_r + IDX_W'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/scel_div.sv =====
module scel_div
  import scel_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic             done,
  output logic [DIV_W-1:0] quot
);

  logic [NB_W-1:0]  cnt_r;
  logic [DIV_W-1:0] q_r;
  logic [DSR_W-1:0] rem_r;
  logic [DSR_W-1:0] dsr_r;
  logic             done_r;
  logic [DSR_W:0]   rem2;
  logic             ge;

  assign rem2 = {rem_r, q_r[DIV_W-1]};
  assign ge   = (rem2 >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        // align so only the low nbits of the dividend get walked
        q_r   <= req.dividend << (NB_W'(DIV_W) - req.nbits);
        rem_r <= '0;
        dsr_r <= req.divisor;
        cnt_r <= req.nbits;
      end else if (cnt_r != '0) begin
        rem_r  <= ge ? DSR_W'(rem2 - {1'b0, dsr_r}) : DSR_W'(rem2);
        q_r    <= {q_r[DIV_W-2:0], ge};
        cnt_r  <= cnt_r - NB_W'(1);
        done_r <= (cnt_r == NB_W'(1));
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== rtl/scel_back.sv =====
module scel_back
  import scel_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             q_valid,
  input  row_desc_t        q_head,
  output logic             q_pop,
  output logic [IDX_W:0]   row_raddr,
  input  logic [ROW_W-1:0] row_rdata,
  output bank_rel_t        rel,
  output div_req_t         div_req,
  input  logic             div_done,
  input  logic [DIV_W-1:0] div_quot,
  scel_out_if.source       out_chan
);

  typedef enum logic [4:0] {
    B_IDLE, B_SDIV, B_MAX_RD, B_MAX_USE, B_EXP_RD, B_EXP_LD, B_EXP_STEP, B_EXP_FIN,
    B_EV_RD, B_EV_LD, B_EV_PDIV, B_EV_CLIP, B_NL_STEP, B_NL_FIN, B_LOSS, B_GDIV,
    B_MDIV, B_GSTORE, B_ROW_END, B_BDIV, B_EM_RD, B_EM_LD, B_EM_OUT
  } state_t;

  state_t             state_r;
  logic               bank_r;
  logic [LEN_W-1:0]   len_r;
  logic [IDX_W-1:0]   j_r;
  logic [15:0]        sl_r;
  logic signed [23:0] mx_r;
  logic [20:0]        q_r;
  logic [4:0]         i_r;
  logic [30:0]        acc_r;
  logic [21:0]        sum_r;
  logic [17:0]        tv_r;
  logic signed [24:0] p_r;
  logic [15:0]        pc_r;
  logic [31:0]        x_r;
  logic [29:0]        y_r;
  logic [3:0]         k_r;
  logic [19:0]        nl_r;
  logic [26:0]        row_loss_r;
  logic [33:0]        mag_r;
  logic               neg_r;
  logic [47:0]        batch_sum_r;
  logic [15:0]        row_cnt_r;
  logic               last_batch_r;
  logic [47:0]        blos_r;

  logic               out_valid_r;
  logic [4:0]         out_idx_r;
  logic [31:0]        out_grad_r;
  logic [47:0]        out_blos_r;
  logic               out_lrow_r;
  logic               out_lbatch_r;

  logic signed [23:0] rd_score;
  logic [16:0]        rd_target;
  logic [16:0]        exp_rdata;
  logic [31:0]        grad_rdata;
  logic               logits;
  logic               mean;
  logic [15:0]        rows_eff;
  logic               last_j;
  logic [24:0]        qdiff;
  logic [60:0]        acc_prod;
  logic [60:0]        acc_rnd;
  logic [31:0]        exp_sum;
  logic [16:0]        exp_fin;
  logic [33:0]        t_mul;
  logic [17:0]        t_new;
  logic [15:0]        pc_clip;
  logic [3:0]         k_enc;
  logic [31:0]        x_init;
  logic [31:0]        x_sum;
  logic               take;
  logic [34:0]        y_full;
  logic [37:0]        loss_prod;
  logic signed [25:0] g_logit;
  logic [25:0]        mag_l;
  logic [31:0]        grad_sat;
  logic [48:0]        bsum_wide;
  logic [47:0]        batch_new;
  logic               last_batch;

  assign rd_score  = signed'(row_rdata[ROW_W-1:17]);
  assign rd_target = row_rdata[16:0];
  assign logits    = cfg.scores_are_logits;
  assign mean      = (cfg.reduction_mode == RED_MEAN);
  assign rows_eff  = (cfg.batch_rows == 16'd0) ? 16'd1 : cfg.batch_rows;
  assign last_j    = ((LEN_W'(j_r) + LEN_W'(1)) == len_r);
  assign row_raddr = {bank_r, j_r};

  assign qdiff     = 25'({mx_r[23], mx_r} - {rd_score[23], rd_score});
  assign acc_prod  = 61'(acc_r) * 61'(exp_tab_q30(5'(i_r + 5'd8)));
  assign acc_rnd   = acc_prod + 61'(1 << 29);
  assign exp_sum   = 32'(acc_r) + 32'(1 << 13);
  assign exp_fin   = exp_sum[30:14];

  assign t_mul = 34'(rd_target) * 34'(17'h10000 - {1'b0, cfg.smoothing_amount});
  assign t_new = 18'(t_mul[33:FRAC_BITS]) + 18'(sl_r);

  always_comb begin
    if (p_r < 25'sd1) begin
      pc_clip = 16'd1;
    end else if (p_r > 25'sd65535) begin
      pc_clip = 16'hFFFF;
    end else begin
      pc_clip = p_r[15:0];
    end
    k_enc = 4'd0;
    for (int b = 0; b < 16; b++) begin
      if (pc_clip[b]) begin
        k_enc = 4'(b);
      end
    end
  end

  assign x_init    = 32'(pc_clip) << (5'd30 - 5'(k_enc));
  assign x_sum     = x_r + (x_r >> i_r);
  assign take      = (x_sum <= 32'h8000_0000);
  assign y_full    = 35'(y_r) + 35'(4'd15 - k_r) * 35'(LN2_Q30) + 35'(1 << 13);
  assign loss_prod = 38'(tv_r) * 38'(nl_r);
  assign g_logit   = 26'(p_r) - signed'(26'(tv_r));
  assign mag_l     = (g_logit < 0) ? 26'(-g_logit) : 26'(g_logit);

  always_comb begin
    if (neg_r) begin
      grad_sat = (mag_r >= 34'h0_8000_0000) ? 32'h8000_0000 : 32'(-mag_r[31:0]);
    end else begin
      grad_sat = (mag_r >= 34'h0_8000_0000) ? 32'h7FFF_FFFF : mag_r[31:0];
    end
  end

  assign bsum_wide  = 49'(batch_sum_r) + 49'(row_loss_r);
  assign batch_new  = bsum_wide[48] ? 48'hFFFF_FFFF_FFFF : bsum_wide[47:0];
  assign last_batch = ((17'(row_cnt_r) + 17'd1) >= 17'(rows_eff));

  scel_ram #(.DEPTH(MAX_CLASSES), .WIDTH(17)) u_exp_ram (
    .clk   (clk),
    .we    (state_r == B_EXP_FIN),
    .waddr (j_r),
    .wdata (exp_fin),
    .raddr (j_r),
    .rdata (exp_rdata)
  );

  scel_ram #(.DEPTH(MAX_CLASSES), .WIDTH(32)) u_grad_ram (
    .clk   (clk),
    .we    (state_r == B_GSTORE),
    .waddr (j_r),
    .wdata (grad_sat),
    .raddr (j_r),
    .rdata (grad_rdata)
  );

  always_comb begin
    div_req = '0;
    case (state_r)
      B_IDLE: begin
        div_req.start    = q_valid;
        div_req.dividend = DIV_W'(cfg.smoothing_amount);
        div_req.divisor  = DSR_W'(q_head.len);
        div_req.nbits    = NB_W'(16);
      end
      B_EV_LD: begin
        div_req.start    = logits;
        div_req.dividend = DIV_W'({exp_rdata, 16'd0});
        div_req.divisor  = sum_r;
        div_req.nbits    = NB_W'(33);
      end
      B_LOSS: begin
        if (!logits) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'({tv_r, 16'd0});
          div_req.divisor  = DSR_W'(pc_r);
        end else begin
          div_req.start    = mean;
          div_req.dividend = DIV_W'(mag_l);
          div_req.divisor  = DSR_W'(rows_eff);
        end
        div_req.nbits = NB_W'(34);
      end
      B_GDIV: begin
        div_req.start    = div_done && mean;
        div_req.dividend = DIV_W'(div_quot[33:0]);
        div_req.divisor  = DSR_W'(rows_eff);
        div_req.nbits    = NB_W'(34);
      end
      B_ROW_END: begin
        div_req.start    = last_batch && mean;
        div_req.dividend = batch_new;
        div_req.divisor  = DSR_W'(rows_eff);
        div_req.nbits    = NB_W'(DIV_W);
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  assign q_pop     = (state_r == B_IDLE) && q_valid;
  assign rel.valid = (state_r == B_EM_OUT) && out_chan.ready && last_j;
  assign rel.bank  = bank_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      batch_sum_r  <= '0;
      row_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            bank_r     <= q_head.bank;
            len_r      <= q_head.len;
            j_r        <= '0;
            sum_r      <= '0;
            row_loss_r <= '0;
            state_r    <= B_SDIV;
          end
        end
        B_SDIV: begin
          if (div_done) begin
            sl_r    <= div_quot[15:0];
            state_r <= logits ? B_MAX_RD : B_EV_RD;
          end
        end
        B_MAX_RD: begin
          state_r <= B_MAX_USE;
        end
        B_MAX_USE: begin
          if ((j_r == '0) || (rd_score > mx_r)) begin
            mx_r <= rd_score;
          end
          if (last_j) begin
            j_r     <= '0;
            state_r <= B_EXP_RD;
          end else begin
            j_r     <= j_r + IDX_W'(1);
            state_r <= B_MAX_RD;
          end
        end
        B_EXP_RD: begin
          state_r <= B_EXP_LD;
        end
        B_EXP_LD: begin
          // far below the maximum rounds to zero
          if (qdiff[24:21] != 4'd0) begin
            acc_r   <= '0;
            state_r <= B_EXP_FIN;
          end else begin
            acc_r   <= 31'(1 << 30);
            q_r     <= qdiff[20:0];
            i_r     <= '0;
            state_r <= B_EXP_STEP;
          end
        end
        B_EXP_STEP: begin
          if (q_r[i_r]) begin
            acc_r <= acc_rnd[60:30];
          end
          if (i_r == 5'd20) begin
            state_r <= B_EXP_FIN;
          end else begin
            i_r <= i_r + 5'd1;
          end
        end
        B_EXP_FIN: begin
          sum_r <= sum_r + 22'(exp_fin);
          if (last_j) begin
            j_r     <= '0;
            state_r <= B_EV_RD;
          end else begin
            j_r     <= j_r + IDX_W'(1);
            state_r <= B_EXP_RD;
          end
        end
        B_EV_RD: begin
          state_r <= B_EV_LD;
        end
        B_EV_LD: begin
          tv_r <= t_new;
          if (logits) begin
            state_r <= B_EV_PDIV;
          end else begin
            p_r     <= 25'(rd_score);
            state_r <= B_EV_CLIP;
          end
        end
        B_EV_PDIV: begin
          if (div_done) begin
            p_r     <= signed'(25'(div_quot[16:0]));
            state_r <= B_EV_CLIP;
          end
        end
        B_EV_CLIP: begin
          pc_r    <= pc_clip;
          k_r     <= k_enc;
          x_r     <= x_init;
          y_r     <= '0;
          i_r     <= 5'd1;
          state_r <= B_NL_STEP;
        end
        B_NL_STEP: begin
          if (take) begin
            x_r <= x_sum;
            y_r <= y_r + 30'(ln_tab_q30(5'(i_r - 5'd1)));
          end
          if (i_r == 5'd30) begin
            state_r <= B_NL_FIN;
          end else begin
            i_r <= i_r + 5'd1;
          end
        end
        B_NL_FIN: begin
          nl_r    <= y_full[33:14];
          state_r <= B_LOSS;
        end
        B_LOSS: begin
          row_loss_r <= row_loss_r + 27'(loss_prod[37:FRAC_BITS]);
          if (!logits) begin
            neg_r   <= 1'b1;
            state_r <= B_GDIV;
          end else begin
            neg_r <= (g_logit < 0);
            if (mean) begin
              state_r <= B_MDIV;
            end else begin
              mag_r   <= 34'(mag_l);
              state_r <= B_GSTORE;
            end
          end
        end
        B_GDIV: begin
          if (div_done) begin
            if (mean) begin
              state_r <= B_MDIV;
            end else begin
              mag_r   <= div_quot[33:0];
              state_r <= B_GSTORE;
            end
          end
        end
        B_MDIV: begin
          if (div_done) begin
            mag_r   <= div_quot[33:0];
            state_r <= B_GSTORE;
          end
        end
        B_GSTORE: begin
          if (last_j) begin
            state_r <= B_ROW_END;
          end else begin
            j_r     <= j_r + IDX_W'(1);
            state_r <= B_EV_RD;
          end
        end
        B_ROW_END: begin
          j_r          <= '0;
          last_batch_r <= last_batch;
          if (last_batch) begin
            batch_sum_r <= '0;
            row_cnt_r   <= '0;
            blos_r      <= batch_new;
            state_r     <= mean ? B_BDIV : B_EM_RD;
          end else begin
            batch_sum_r <= batch_new;
            row_cnt_r   <= row_cnt_r + 16'd1;
            state_r     <= B_EM_RD;
          end
        end
        B_BDIV: begin
          if (div_done) begin
            blos_r  <= div_quot;
            state_r <= B_EM_RD;
          end
        end
        B_EM_RD: begin
          state_r <= B_EM_LD;
        end
        B_EM_LD: begin
          out_valid_r  <= 1'b1;
          out_idx_r    <= j_r;
          out_grad_r   <= grad_rdata;
          out_blos_r   <= (last_j && last_batch_r) ? blos_r : 48'd0;
          out_lrow_r   <= last_j;
          out_lbatch_r <= last_j && last_batch_r;
          state_r      <= B_EM_OUT;
        end
        B_EM_OUT: begin
          // hold the word until the sink takes it
          if (out_chan.ready) begin
            out_valid_r <= 1'b0;
            if (last_j) begin
              state_r <= B_IDLE;
            end else begin
              j_r     <= j_r + IDX_W'(1);
              state_r <= B_EM_RD;
            end
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.class_index   = out_idx_r;
  assign out_chan.gradient      = out_grad_r;
  assign out_chan.row_loss      = 32'(row_loss_r);
  assign out_chan.batch_loss    = out_blos_r;
  assign out_chan.last_of_row   = out_lrow_r;
  assign out_chan.last_of_batch = out_lbatch_r;

endmodule

// ===== rtl/softmax_cross_entropy_loss_grad.sv =====
// Softmax cross-entropy loss and gradient, fixed point Q16.
// in_chan takes one word per class (score, target); a row closes after
// class_count words (clamped to 1..32). out_chan returns one word per
// class of that row, in class order, with the row loss on every word and
// the reduced batch loss on the final word of the batch. cfg_chan writes
// the five registers by index; it is always ready and must be used only
// while the block is idle. The front accepts one word per cycle into one
// of two row banks, so the next row loads while the back works on the
// current one; it stalls only when both banks hold unfinished rows.
// The back is a sequencer around a shared bit-serial divider; its work per
// class is set by the 16..48-step divider, the 21-step exp multiply loop
// and the 30-step log iteration, plus per-row work and a further division
// at a mean batch end; each result word then passes through read, load and
// output states and waits out any sink stall.
// A stalled sink holds the result word and, once both banks fill, in_chan.
// Reset clears the counters, the batch sum and the registers to their
// defaults; row storage is not cleared.
module softmax_cross_entropy_loss_grad
  import scel_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  scel_in_if.sink   in_chan,
  scel_out_if.source out_chan,
  scel_cfg_if.sink  cfg_chan
);

  cfg_t             cfg_r;
  row_wr_t          row_wr;
  logic             q_push;
  row_desc_t        q_push_desc;
  logic             q_pop;
  logic             q_valid;
  row_desc_t        q_head;
  logic [1:0]       q_count;
  bank_rel_t        rel;
  logic [IDX_W:0]   row_raddr;
  logic [ROW_W-1:0] row_rdata;
  div_req_t         div_req;
  logic             div_done;
  logic [DIV_W-1:0] div_quot;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.class_count       <= 6'd32;
      cfg_r.batch_rows        <= 16'd1;
      cfg_r.reduction_mode    <= RED_MEAN;
      cfg_r.scores_are_logits <= 1'b0;
      cfg_r.smoothing_amount  <= 16'd0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_CLASS_COUNT: cfg_r.class_count       <= cfg_chan.data[5:0];
        CFG_BATCH_ROWS:  cfg_r.batch_rows        <= cfg_chan.data;
        CFG_REDUCTION:   cfg_r.reduction_mode    <= cfg_chan.data[1:0];
        CFG_LOGITS:      cfg_r.scores_are_logits <= cfg_chan.data[0];
        CFG_SMOOTHING:   cfg_r.smoothing_amount  <= cfg_chan.data;
        default: begin
        end
      endcase
    end
  end

  scel_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg       (cfg_r),
    .rel       (rel),
    .row_wr    (row_wr),
    .push      (q_push),
    .push_desc (q_push_desc)
  );

  scel_ram #(.DEPTH(2 * MAX_CLASSES), .WIDTH(ROW_W)) u_row_ram (
    .clk   (clk),
    .we    (row_wr.we),
    .waddr (row_wr.addr),
    .wdata (row_wr.data),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  scel_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_desc  (q_push_desc),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head),
    .count      (q_count)
  );

  scel_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  scel_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .row_raddr (row_raddr),
    .row_rdata (row_rdata),
    .rel       (rel),
    .div_req   (div_req),
    .div_done  (div_done),
    .div_quot  (div_quot),
    .out_chan  (out_chan)
  );

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_count != 2'd2))
    else $error("row queue overflow");

  a_batch_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.last_of_batch) |-> out_chan.last_of_row)
    else $error("batch end without row end");

  a_blos_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.last_of_batch) |-> (out_chan.batch_loss == 48'd0))
    else $error("batch loss on a non-final word");

  a_pop_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_count != 2'd0))
    else $error("row queue underflow");

endmodule

// ===== tb/softmax_cross_entropy_loss_grad_test.sv =====
module softmax_cross_entropy_loss_grad_test;
  import scel_pkg::*;

  typedef struct {
    logic [23:0] score;
    logic [16:0] target;
  } in_word_t;

  typedef struct {
    logic [4:0]  class_index;
    logic [31:0] gradient;
    logic [31:0] row_loss;
    logic [47:0] batch_loss;
    logic        last_of_row;
    logic        last_of_batch;
  } grad_word_t;

  localparam logic [63:0] SAT48 = 64'hFFFF_FFFF_FFFF;

  logic clk = 0;
  logic rst_n = 0;

  scel_in_if in_chan();
  scel_out_if out_chan();
  scel_cfg_if cfg_chan();

  softmax_cross_entropy_loss_grad dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan), .cfg_chan(cfg_chan)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  logic [5:0]  m_class_count = 6'd32;
  logic [15:0] m_batch_rows = 16'd1;
  logic [1:0]  m_reduction = 2'd0;
  logic        m_logits = 1'b0;
  logic [15:0] m_smoothing = 16'd0;
  logic [23:0] m_scores [MAX_CLASSES];
  logic [16:0] m_targets [MAX_CLASSES];
  int unsigned m_class_ctr = 0;
  int unsigned m_row_ctr = 0;
  logic [63:0] m_batch_sum = 0;

  in_word_t   pending_words [$];
  grad_word_t expected_grads [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;

  function automatic longint sx24(logic [23:0] v);
    return longint'($signed(v));
  endfunction

  function automatic logic [63:0] exp_neg_q(logic [63:0] q);
    logic [63:0] acc;
    logic [63:0] tv;
    acc = 64'd1 << 30;
    if ((q >> FRAC_BITS) >= 32) return 0;
    for (int i = 0; i <= FRAC_BITS + 4; i++)
      if (q[i]) begin
        tv = 64'(exp_tab_q30(5'(i + 24 - FRAC_BITS)));
        acc = (acc * tv + (64'd1 << 29)) >> 30;
      end
    return (acc + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
  endfunction

  function automatic logic [63:0] neg_ln_q(logic [63:0] p);
    int k;
    logic [63:0] x, y, t;
    k = 0;
    y = 0;
    for (int i = 0; i < FRAC_BITS; i++) if (p[i]) k = i;
    x = p << (30 - k);
    for (int i = 1; i <= 30; i++) begin
      t = x + (x >> i);
      if (t <= (64'd2 << 30)) begin
        x = t;
        y += 64'(ln_tab_q30(5'(i - 1)));
      end
    end
    y += 64'(FRAC_BITS - 1 - k) * 64'(LN2_Q30);
    return (y + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
  endfunction

  task automatic predict_grads(in_word_t w);
    int unsigned n, rows, idx, len;
    logic [63:0] s_fx, sum, row_loss, blos, t, ev;
    logic [63:0] tv [MAX_CLASSES];
    longint pv [MAX_CLASSES];
    logic [63:0] exps [MAX_CLASSES];
    longint mx, p, pc, g;
    bit mean, last_batch;
    grad_word_t r;
    n = m_class_count;
    rows = m_batch_rows;
    idx = m_class_ctr;
    sum = 0;
    row_loss = 0;
    blos = 0;
    if (n < 1) n = 1;
    if (n > MAX_CLASSES) n = MAX_CLASSES;
    if (rows < 1) rows = 1;
    if (idx >= MAX_CLASSES) idx = MAX_CLASSES - 1;
    mean = (m_reduction == RED_MEAN);
    m_scores[idx] = w.score;
    m_targets[idx] = w.target;
    if (idx + 1 < n) begin
      m_class_ctr = idx + 1;
      return;
    end
    len = idx + 1;
    m_class_ctr = 0;
    s_fx = (64'(m_smoothing) << FRAC_BITS) >> 16;
    if (m_logits) begin
      mx = sx24(m_scores[0]);
      for (int j = 1; j < len; j++) if (sx24(m_scores[j]) > mx) mx = sx24(m_scores[j]);
      for (int j = 0; j < len; j++) begin
        ev = exp_neg_q(64'(mx - sx24(m_scores[j])));
        exps[j] = ev[31:0];
        sum += exps[j];
      end
    end
    for (int j = 0; j < len; j++) begin
      t = 64'(m_targets[j]);
      if (s_fx != 0) t = ((t * ((64'd1 << FRAC_BITS) - s_fx)) >> FRAC_BITS) + s_fx / len;
      if (m_logits) p = longint'((exps[j] << FRAC_BITS) / sum);
      else p = sx24(m_scores[j]);
      pc = (p < 1) ? 1 : p;
      if (pc > (1 << FRAC_BITS) - 1) pc = (1 << FRAC_BITS) - 1;
      row_loss += (t * neg_ln_q(64'(pc))) >> FRAC_BITS;
      tv[j] = t;
      pv[j] = m_logits ? p : pc;
    end
    m_batch_sum += row_loss;
    if (m_batch_sum > SAT48) m_batch_sum = SAT48;
    last_batch = (m_row_ctr + 1 >= rows);
    if (last_batch) begin
      blos = mean ? m_batch_sum / rows : m_batch_sum;
      m_batch_sum = 0;
      m_row_ctr = 0;
    end else begin
      m_row_ctr = (m_row_ctr + 1) & 16'hFFFF;
    end
    for (int j = 0; j < len; j++) begin
      if (m_logits) g = pv[j] - longint'(tv[j]);
      else g = -longint'((tv[j] << FRAC_BITS) / 64'(pv[j]));
      if (mean) g = (g < 0) ? -((-g) / longint'(rows)) : g / longint'(rows);
      if (g > 64'sd2147483647) g = 64'sd2147483647;
      if (g < -64'sd2147483648) g = -64'sd2147483648;
      r.class_index = 5'(j);
      r.gradient = g[31:0];
      r.row_loss = (row_loss > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : row_loss[31:0];
      r.last_of_row = (j + 1 == len);
      r.last_of_batch = r.last_of_row && last_batch;
      r.batch_loss = r.last_of_batch ? blos[47:0] : 48'd0;
      expected_grads.push_back(r);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) predict_grads('{in_chan.score, in_chan.target});
      if (!in_chan.valid || in_chan.ready) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_chan.valid <= 1'b1;
          in_chan.score <= pending_words[0].score;
          in_chan.target <= pending_words[0].target;
          void'(pending_words.pop_front());
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    grad_word_t e;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_grads.size() == 0) begin
          $error("unexpected gradient word class %0d", out_chan.class_index);
          errors++;
        end else begin
          e = expected_grads.pop_front();
          if (out_chan.class_index !== e.class_index) begin
            $error("class_index exp %0d got %0d", e.class_index, out_chan.class_index);
            errors++;
          end
          if (out_chan.gradient !== e.gradient) begin
            $error("gradient exp %0d got %0d", $signed(e.gradient), out_chan.gradient);
            errors++;
          end
          if (out_chan.row_loss !== e.row_loss) begin
            $error("row_loss exp %0d got %0d", e.row_loss, out_chan.row_loss);
            errors++;
          end
          if (out_chan.batch_loss !== e.batch_loss) begin
            $error("batch_loss exp %0d got %0d", e.batch_loss, out_chan.batch_loss);
            errors++;
          end
          if (out_chan.last_of_row !== e.last_of_row) begin
            $error("last_of_row exp %0d got %0d", e.last_of_row, out_chan.last_of_row);
            errors++;
          end
          if (out_chan.last_of_batch !== e.last_of_batch) begin
            $error("last_of_batch exp %0d got %0d", e.last_of_batch, out_chan.last_of_batch);
            errors++;
          end
        end
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data <= val;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    cfg_chan.valid <= 1'b0;
    case (idx)
      CFG_CLASS_COUNT: m_class_count = val[5:0];
      CFG_BATCH_ROWS:  m_batch_rows = val;
      CFG_REDUCTION:   m_reduction = val[1:0];
      CFG_LOGITS:      m_logits = val[0];
      CFG_SMOOTHING:   m_smoothing = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_chan.valid || expected_grads.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic setup(int cc, int br, int red, int lg, int sm);
    write_reg(CFG_CLASS_COUNT, 16'(cc));
    write_reg(CFG_BATCH_ROWS, 16'(br));
    write_reg(CFG_REDUCTION, 16'(red));
    write_reg(CFG_LOGITS, 16'(lg));
    write_reg(CFG_SMOOTHING, 16'(sm));
  endtask

  function automatic in_word_t rand_word(bit lg);
    in_word_t w;
    case ($urandom_range(5))
      0: w.score = 24'($urandom);
      1: w.score = lg ? 24'($signed($urandom_range(20'h3FFFF)) - 24'sh20000) : 24'h010000;
      2: w.score = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      default: w.score = lg ? 24'($urandom_range(24'h7FFFF)) : 24'($urandom_range(24'h10000));
    endcase
    case ($urandom_range(4))
      0: w.target = 17'($urandom);
      1: w.target = 17'h10000;
      2: w.target = 0;
      default: w.target = 17'($urandom_range(17'h10000));
    endcase
    return w;
  endfunction

  task automatic random_phase(int nwords, int cc, bit lg, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < nwords; i++) pending_words.push_back(rand_word(lg));
    drain();
  endtask

  initial begin
    in_chan.valid = 0;
    in_chan.score = 0;
    in_chan.target = 0;
    out_chan.ready = 0;
    cfg_chan.valid = 0;
    cfg_chan.index = 0;
    cfg_chan.data = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: probabilities, extremes and clipping
    setup(4, 1, 1, 0, 0);
    pending_words.push_back('{24'h010000, 17'h10000});
    pending_words.push_back('{24'h000000, 17'h00000});
    pending_words.push_back('{24'h800000, 17'h1FFFF});
    pending_words.push_back('{24'h7FFFFF, 17'h08000});
    drain();
    // zero class count acts as one, batch rows zero acts as one, code three
    setup(0, 0, 3, 1, 16'hFFFF);
    pending_words.push_back('{24'h7FFFFF, 17'h10000});
    pending_words.push_back('{24'h800000, 17'h00001});
    drain();
    // oversize class count, logits with wide spread, mean over two rows
    setup(63, 2, 0, 1, 16'h1000);
    for (int i = 0; i < 32; i++)
      pending_words.push_back('{(i == 0) ? 24'h7FFFFF : 24'h800000 + 24'(i), 17'(i * 2048)});
    drain();
    pending_words.push_back('{24'h000000, 17'h10000});
    drain();
    // class count lowered mid-row: row closes on next word
    setup(5, 1, 0, 0, 0);
    pending_words.push_back('{24'h004000, 17'h04000});
    pending_words.push_back('{24'h008000, 17'h08000});
    pending_words.push_back('{24'h002000, 17'h02000});
    drain();
    write_reg(CFG_CLASS_COUNT, 16'd2);
    pending_words.push_back('{24'h001000, 17'h01000});
    drain();
    // batch rows lowered mid-batch
    setup(1, 3, 0, 0, 0);
    pending_words.push_back('{24'h008000, 17'h10000});
    drain();
    write_reg(CFG_BATCH_ROWS, 16'd1);
    pending_words.push_back('{24'h004000, 17'h10000});
    drain();

    // random phases
    setup(3, 4, 0, 1, 0);
    random_phase(30, 3, 1, 0, 0);
    setup(8, 65535, 0, 0, 16'h0800);
    random_phase(48, 8, 0, 74, 0);
    setup(2, 3, 1, 1, 16'hFFFF);
    random_phase(30, 2, 1, 0, 74);
    setup(1, 1, 2, 0, 0);
    random_phase(30, 1, 0, 11, 11);
    // long receiver hold-off while sender keeps offering
    setup(4, 2, 0, 1, 16'h2000);
    hold_off_cycles = 3000;
    random_phase(64, 4, 1, 0, 0);
    setup(32, 1, 1, 0, 0);
    random_phase(64, 32, 0, 11, 11);

    repeat (200) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

endmodule
